// ===== hw/rtl/csdc_pkg.sv =====
// Shared types, codes and small decode functions of the clock, stopwatch and display block.
// Used by csdc_core, the top level and the checker; depends on nothing else.
package csdc_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int SCAN_W     = $clog2(NUM_DIGITS);

    // Event codes carried in cmd.
    localparam logic [1:0] CMD_SECOND = 2'd0;
    localparam logic [1:0] CMD_CHIME  = 2'd1;
    localparam logic [1:0] CMD_SCAN   = 2'd2;
    localparam logic [1:0] CMD_BUTTON = 2'd3;

    // Ladder codes of the four buttons and of no button pressed.
    localparam logic [9:0] ADC_NONE  = 10'd819;
    localparam logic [9:0] ADC_SET   = 10'd0;
    localparam logic [9:0] ADC_SW    = 10'd512;
    localparam logic [9:0] ADC_PHASE = 10'd683;
    localparam logic [9:0] ADC_DISP  = 10'd768;

    // Message codes.
    localparam logic [3:0] MSG_NONE     = 4'd0;
    localparam logic [3:0] MSG_ADJ_H    = 4'd1;
    localparam logic [3:0] MSG_ADJ_M    = 4'd2;
    localparam logic [3:0] MSG_ADJ_S    = 4'd3;
    localparam logic [3:0] MSG_SW_ON    = 4'd4;
    localparam logic [3:0] MSG_SW_OFF   = 4'd5;
    localparam logic [3:0] MSG_DISP_OFF = 4'd6;
    localparam logic [3:0] MSG_DISP_ON  = 4'd7;
    localparam logic [3:0] MSG_MINUTE   = 4'd8;
    localparam logic [3:0] MSG_HOUR     = 4'd9;
    localparam logic [3:0] MSG_MIDNIGHT = 4'd10;

    // Setting phases.
    localparam logic [1:0] PHASE_HOURS   = 2'd0;
    localparam logic [1:0] PHASE_MINUTES = 2'd1;
    localparam logic [1:0] PHASE_SECONDS = 2'd2;

    localparam logic [7:0] CHIME_HALF_RESET = 8'd100;

    typedef enum logic [2:0] {
        BTN_NONE    = 3'd0,
        BTN_SET     = 3'd1,
        BTN_SW      = 3'd2,
        BTN_PHASE   = 3'd3,
        BTN_DISP    = 3'd4,
        BTN_INVALID = 3'd7
    } btn_t;

    typedef struct packed {
        logic [6:0]            segments;
        logic [NUM_DIGITS-1:0] anodes;
        logic                  led;
        logic [4:0]            hours;
        logic [5:0]            minutes;
        logic [5:0]            seconds;
        logic                  running;
        logic                  display_off;
        logic [3:0]            message;
    } result_t;

    // Seven-segment pattern, bit 0 is segment a; codes above nine are blank.
    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Tens digit of a value below 64, by a short compare chain.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - 6'(tens_of(v)) * 6'd10;
        return r[3:0];
    endfunction

endpackage

// ===== hw/rtl/csdc_core.sv =====
// State and event logic of the clock: time, setting, stopwatch, chime, scan and buttons.
// Depends on csdc_pkg; instantiated by the top level.
module csdc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [1:0]          cmd,
    input  logic [9:0]          adc_value,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    output csdc_pkg::result_t   res
);
    import csdc_pkg::*;

    logic [7:0]            half_reg;
    logic [5:0]            sec_reg, sec_next;
    logic [5:0]            min_reg, min_next;
    logic [4:0]            hour_reg, hour_next;
    logic [3:0]            digits_reg [NUM_DIGITS];
    logic [3:0]            digits_next [NUM_DIGITS];
    logic [5:0]            setv_reg, setv_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  run_reg, run_next;
    logic                  parity_reg, parity_next;
    logic                  off_reg, off_next;
    btn_t                  last_reg, last_next;
    logic                  chime_reg, chime_next;
    logic [4:0]            blinks_reg, blinks_next;
    logic [7:0]            ticks_reg, ticks_next;
    logic                  cphase_reg, cphase_next;
    logic [SCAN_W-1:0]     scan_reg, scan_next;
    logic [6:0]            seg_reg, seg_next;
    logic [NUM_DIGITS-1:0] anode_reg, anode_next;
    logic                  led_reg, led_next;

    logic [6:0]        sec_w;
    logic [6:0]        min_w;
    logic [5:0]        hour_w;
    logic [7:0]        tick_w;
    logic [5:0]        setv_w;
    logic [SCAN_W-1:0] idx;
    logic [1:0]        phase_w;
    btn_t              btn;
    logic              refresh;
    logic [3:0]        msg;

    always_comb begin
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        setv_next   = setv_reg;
        phase_next  = phase_reg;
        run_next    = run_reg;
        parity_next = parity_reg;
        off_next    = off_reg;
        last_next   = last_reg;
        chime_next  = chime_reg;
        blinks_next = blinks_reg;
        ticks_next  = ticks_reg;
        cphase_next = cphase_reg;
        scan_next   = scan_reg;
        seg_next    = seg_reg;
        anode_next  = anode_reg;
        led_next    = led_reg;
        sec_w       = {1'b0, sec_reg};
        min_w       = {1'b0, min_reg};
        hour_w      = {1'b0, hour_reg};
        tick_w      = ticks_reg + 8'd1;
        setv_w      = setv_reg + 6'd1;
        idx         = '0;
        phase_w     = phase_reg + 2'd1;
        btn         = BTN_INVALID;
        refresh     = 1'b0;
        msg         = MSG_NONE;

        case (cmd)
            CMD_SECOND: begin
                if (run_reg) begin
                    sec_w = sec_w + 7'd1;
                    if (sec_w >= 7'd60) begin
                        sec_w = '0;
                        min_w = min_w + 7'd1;
                        if (min_w < 7'd60) msg = MSG_MINUTE;
                    end
                    if (min_w >= 7'd60) begin
                        min_w  = '0;
                        hour_w = hour_w + 6'd1;
                        if (hour_w < 6'd24) begin
                            msg         = MSG_HOUR;
                            chime_next  = 1'b1;
                            blinks_next = hour_w[4:0];
                            ticks_next  = '0;
                            cphase_next = 1'b0;
                        end
                    end
                    if (hour_w >= 6'd24) begin
                        hour_w = '0;
                        msg    = MSG_MIDNIGHT;
                    end
                    sec_next  = sec_w[5:0];
                    min_next  = min_w[5:0];
                    hour_next = hour_w[4:0];
                    refresh   = 1'b1;
                end
            end
            CMD_CHIME: begin
                if (chime_reg) begin
                    ticks_next = tick_w;
                    if (tick_w >= half_reg) begin
                        ticks_next = '0;
                        if (!cphase_reg) begin
                            led_next    = 1'b1;
                            cphase_next = 1'b1;
                        end else begin
                            led_next    = 1'b0;
                            cphase_next = 1'b0;
                            if (blinks_reg <= 5'd1) begin
                                blinks_next = '0;
                                chime_next  = 1'b0;
                            end else begin
                                blinks_next = blinks_reg - 5'd1;
                            end
                        end
                    end
                end
            end
            CMD_SCAN: begin
                if (!off_reg) begin
                    idx        = (scan_reg >= SCAN_W'(NUM_DIGITS)) ? '0 : scan_reg;
                    seg_next   = seg_decode(digits_reg[idx]);
                    anode_next = NUM_DIGITS'(1) << idx;
                    scan_next  = (idx == SCAN_W'(NUM_DIGITS - 1)) ? '0 : idx + SCAN_W'(1);
                end
            end
            default: begin
                case (adc_value)
                    ADC_NONE:  btn = BTN_NONE;
                    ADC_SET:   btn = BTN_SET;
                    ADC_SW:    btn = BTN_SW;
                    ADC_PHASE: btn = BTN_PHASE;
                    ADC_DISP:  btn = BTN_DISP;
                    default:   btn = BTN_INVALID;
                endcase
                last_next = btn;
                if (btn != last_reg && btn != BTN_INVALID) begin
                    case (btn)
                        BTN_NONE: begin
                            led_next = 1'b0;
                            if (off_reg) begin
                                seg_next   = '0;
                                anode_next = '0;
                            end
                        end
                        BTN_SET: begin
                            setv_next = setv_w;
                            refresh   = 1'b1;
                            case (phase_reg)
                                PHASE_HOURS: begin
                                    msg = MSG_ADJ_H;
                                    if (setv_w > 6'd23) setv_next = '0;
                                    hour_next = (setv_w > 6'd23) ? '0 : setv_w[4:0];
                                end
                                PHASE_MINUTES: begin
                                    msg = MSG_ADJ_M;
                                    if (setv_w > 6'd59) setv_next = '0;
                                    min_next = (setv_w > 6'd59) ? '0 : setv_w;
                                end
                                PHASE_SECONDS: begin
                                    msg = MSG_ADJ_S;
                                    if (setv_w > 6'd59) setv_next = '0;
                                    sec_next = (setv_w > 6'd59) ? '0 : setv_w;
                                end
                                default: ;
                            endcase
                        end
                        BTN_SW: begin
                            parity_next = ~parity_reg;
                            if (!parity_reg) begin
                                msg       = MSG_SW_ON;
                                sec_next  = '0;
                                min_next  = '0;
                                hour_next = '0;
                                run_next  = 1'b1;
                            end else begin
                                msg      = MSG_SW_OFF;
                                run_next = 1'b0;
                                refresh  = 1'b1;
                                led_next = 1'b1;
                            end
                        end
                        BTN_PHASE: begin
                            setv_next  = '0;
                            phase_next = phase_w;
                            if (phase_w > PHASE_SECONDS) begin
                                phase_next = PHASE_HOURS;
                                run_next   = 1'b1;
                            end
                        end
                        default: begin
                            off_next = ~off_reg;
                            if (!off_reg) begin
                                msg        = MSG_DISP_OFF;
                                seg_next   = '0;
                                anode_next = '0;
                            end else begin
                                msg = MSG_DISP_ON;
                            end
                        end
                    endcase
                end
            end
        endcase

        for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_next[i] = digits_reg[i];
        end
        if (refresh) begin
            digits_next[0] = tens_of({1'b0, hour_next});
            digits_next[1] = ones_of({1'b0, hour_next});
            digits_next[2] = tens_of(min_next);
            digits_next[3] = ones_of(min_next);
            digits_next[4] = tens_of(sec_next);
            digits_next[5] = ones_of(sec_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg   <= CHIME_HALF_RESET;
            sec_reg    <= '0;
            min_reg    <= '0;
            hour_reg   <= '0;
            setv_reg   <= '0;
            phase_reg  <= PHASE_HOURS;
            run_reg    <= 1'b0;
            parity_reg <= 1'b0;
            off_reg    <= 1'b0;
            last_reg   <= BTN_NONE;
            chime_reg  <= 1'b0;
            blinks_reg <= '0;
            ticks_reg  <= '0;
            cphase_reg <= 1'b0;
            scan_reg   <= '0;
            seg_reg    <= '0;
            anode_reg  <= '0;
            led_reg    <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digits_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) half_reg <= cfg_wr_data;
            if (en) begin
                sec_reg    <= sec_next;
                min_reg    <= min_next;
                hour_reg   <= hour_next;
                setv_reg   <= setv_next;
                phase_reg  <= phase_next;
                run_reg    <= run_next;
                parity_reg <= parity_next;
                off_reg    <= off_next;
                last_reg   <= last_next;
                chime_reg  <= chime_next;
                blinks_reg <= blinks_next;
                ticks_reg  <= ticks_next;
                cphase_reg <= cphase_next;
                scan_reg   <= scan_next;
                seg_reg    <= seg_next;
                anode_reg  <= anode_next;
                led_reg    <= led_next;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    digits_reg[i] <= digits_next[i];
                end
            end
        end
    end

    assign res.segments    = seg_next;
    assign res.anodes      = anode_next;
    assign res.led         = led_next;
    assign res.hours       = hour_next;
    assign res.minutes     = min_next;
    assign res.seconds     = sec_next;
    assign res.running     = run_next;
    assign res.display_off = off_next;
    assign res.message     = msg;

endmodule

// ===== hw/rtl/clock_stopwatch_display_controller_unit.sv =====
// Path: an accepted transaction passes through the input register, then the result register, to m_*.
// Throughput: one transaction per cycle while m_ready does not stall, set by the single state-update step in csdc_core.
// Reset: aresetn is synchronous and active low; it clears the time, all flags, the chime,
// the scan position and the output latches, and sets the chime half period to 100.
// The pipeline holds an input register and a result register; no clearing pass is needed.
// Depends on csdc_pkg and csdc_core.
module clock_stopwatch_display_controller_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [9:0] s_adc_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_segments,
    output logic [5:0] m_anodes,
    output logic       m_led,
    output logic [4:0] m_hours,
    output logic [5:0] m_minutes,
    output logic [5:0] m_seconds,
    output logic       m_running,
    output logic       m_display_off,
    output logic [3:0] m_message,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import csdc_pkg::*;

    // Input register: holds one accepted transaction until the result register can take it.
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [9:0] in_adc_reg;

    // Result register: the finished result waits here while the downstream side stalls.
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_free;
    logic    advance;
    result_t res;

    // The state is updated exactly when a transaction moves from the input register into
    // the result register, so each result reflects the state after its own event.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (out_free) out_valid_reg <= advance;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg <= s_cmd;
            in_adc_reg <= s_adc_value;
        end
        if (advance) out_reg <= res;
    end

    csdc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .cmd         (in_cmd_reg),
        .adc_value   (in_adc_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res)
    );

    assign m_valid       = out_valid_reg;
    assign m_segments    = out_reg.segments;
    assign m_anodes      = out_reg.anodes;
    assign m_led         = out_reg.led;
    assign m_hours       = out_reg.hours;
    assign m_minutes     = out_reg.minutes;
    assign m_seconds     = out_reg.seconds;
    assign m_running     = out_reg.running;
    assign m_display_off = out_reg.display_off;
    assign m_message     = out_reg.message;

endmodule

// ===== hw/rtl/csdc_checker.sv =====
// Port-level checks of the clock block, attached to the top level by the bind below.
// Depends on csdc_pkg for the message codes.
module csdc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_segments,
    input logic [5:0] m_anodes,
    input logic       m_led,
    input logic [4:0] m_hours,
    input logic [5:0] m_minutes,
    input logic [5:0] m_seconds,
    input logic       m_running,
    input logic       m_display_off,
    input logic [3:0] m_message
);
    import csdc_pkg::*;

    // A stalled result keeps its valid, its time, message, anodes, segments and LED.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hours) && $stable(m_minutes)
            && $stable(m_seconds) && $stable(m_message) && $stable(m_anodes)
            && $stable(m_segments) && $stable(m_led))
        else $error("stalled result changed");

    // At most one digit is driven at a time.
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_anodes))
        else $error("more than one anode active");

    // While the display is switched off, the segment and anode latches stay cleared.
    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_display_off |-> m_anodes == '0 && m_segments == '0)
        else $error("display lit while switched off");

    // A midnight event always leaves the time at zero.
    a_midnight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message == MSG_MIDNIGHT |->
            m_hours == '0 && m_minutes == '0 && m_seconds == '0 && m_running)
        else $error("midnight with non-zero time");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind clock_stopwatch_display_controller_unit csdc_checker u_csdc_checker (.*);
